// ----- rtl/mfpb_pkg.sv -----
// Shared types and constants of the multi-format pixel blend unit.
// No dependencies; imported by the front stage, the divider cell and the top level.
package mfpb_pkg;

    // command codes
    localparam logic [1:0] CMD_BLEND = 2'd0;
    localparam logic [1:0] CMD_COPY  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // pixel format codes
    localparam logic [1:0] FMT_RGB  = 2'd0;
    localparam logic [1:0] FMT_RGBX = 2'd1;
    localparam logic [1:0] FMT_RGBA = 2'd2;
    localparam logic [1:0] FMT_A    = 2'd3;

    localparam logic [7:0] BYTE_MAX = 8'hff;

    localparam int unsigned NCH    = 3;                  // colour channels through the divider
    localparam int unsigned QUOT_W = 8;                  // quotient bits, one per divider cell
    localparam int unsigned DIV_W  = 9;                  // da + sa
    localparam int unsigned REM_W  = 17;                 // d*da + s*sa
    localparam int unsigned DSH_W  = DIV_W + QUOT_W - 1; // divisor aligned to the top quotient bit

    typedef struct packed {
        logic                             use_div;
        logic [3:0][7:0]                  bytes;
        logic [NCH-1:0][REM_W-1:0]        rem;
        logic [DSH_W-1:0]                 dsh;
        logic [NCH-1:0][QUOT_W-1:0]       quot;
    } mfpb_stage_t;

endpackage

// ----- rtl/mfpb_front.sv -----
// Front stage: decodes command and format, forms the weighted channel sums
// and all results that need no division. Depends on mfpb_pkg.
module mfpb_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  logic [1:0]           command,
    input  logic [1:0]           pixel_format,
    input  logic [3:0][7:0]      src,
    input  logic [3:0][7:0]      dst,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output mfpb_pkg::mfpb_stage_t dn_data
);
    import mfpb_pkg::*;

    logic                  valid_reg;
    mfpb_stage_t           data_reg;
    mfpb_stage_t           data_next;
    logic [7:0]            w_dst;
    logic [7:0]            sa;
    logic [7:0]            da;
    logic [DIV_W-1:0]      wsum;
    logic [DIV_W-1:0]      asum;
    logic [7:0]            asum_sat;
    logic [DIV_W-1:0]      a0sum;
    logic [7:0]            a0sum_sat;
    logic [NCH-1:0][REM_W-1:0] mix;

    assign sa = src[3];
    assign da = dst[3];

    always_comb
    begin
        // RGBA weights the stored colour by its alpha; RGB/RGBX by 255 - source alpha
        w_dst = (pixel_format == FMT_RGBA) ? da : (BYTE_MAX - sa);
        for (int i = 0; i < NCH; i++)
        begin
            mix[i] = {1'b0, 16'(dst[i] * w_dst)} + {1'b0, 16'(src[i] * sa)};
        end
        wsum      = {1'b0, da} + {1'b0, sa};
        asum      = wsum;
        asum_sat  = (asum >= DIV_W'(BYTE_MAX)) ? BYTE_MAX : asum[7:0];
        a0sum     = {1'b0, dst[0]} + {1'b0, sa};
        a0sum_sat = (a0sum >= DIV_W'(BYTE_MAX)) ? BYTE_MAX : a0sum[7:0];

        data_next.use_div = 1'b0;
        data_next.bytes   = dst;
        data_next.rem     = mix;
        data_next.dsh     = {wsum, {(QUOT_W-1){1'b0}}};
        data_next.quot    = '0;

        unique case (command)
            CMD_BLEND:
            begin
                if (pixel_format == FMT_A)
                begin
                    data_next.bytes[0] = a0sum_sat;
                end
                else if (sa != 8'd0)
                begin
                    if (pixel_format == FMT_RGBA)
                    begin
                        if (sa == BYTE_MAX || da == 8'd0)
                        begin
                            data_next.bytes = src;
                        end
                        else
                        begin
                            data_next.use_div  = 1'b1;
                            data_next.bytes[3] = asum_sat;
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < NCH; i++)
                        begin
                            data_next.bytes[i] = (sa == BYTE_MAX) ? src[i] : mix[i][15:8];
                        end
                        if (pixel_format == FMT_RGBX)
                        begin
                            data_next.bytes[3] = BYTE_MAX;
                        end
                    end
                end
            end
            CMD_COPY:
            begin
                case (pixel_format) inside
                    FMT_A:
                    begin
                        data_next.bytes[0] = sa;
                    end
                    FMT_RGB:
                    begin
                        data_next.bytes[2:0] = src[2:0];
                    end
                    FMT_RGBX:
                    begin
                        data_next.bytes = {BYTE_MAX, src[2], src[1], src[0]};
                    end
                    default:
                    begin
                        data_next.bytes = src;
                    end
                endcase
            end
            CMD_READ:
            begin
                case (pixel_format) inside
                    FMT_A:
                    begin
                        data_next.bytes = {dst[0], 8'd0, 8'd0, 8'd0};
                    end
                    FMT_RGB, FMT_RGBX:
                    begin
                        data_next.bytes[3] = BYTE_MAX;
                    end
                    default:
                    begin
                        data_next.bytes = dst;
                    end
                endcase
            end
            default:
            begin
                data_next.bytes = dst;
            end
        endcase
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ----- rtl/mfpb_div_cell.sv -----
// One restoring-division cell: settles one quotient bit of each colour
// channel and hands the partial remainder on. Depends on mfpb_pkg.
module mfpb_div_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  mfpb_pkg::mfpb_stage_t up_data,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output mfpb_pkg::mfpb_stage_t dn_data
);
    import mfpb_pkg::*;

    logic        valid_reg;
    mfpb_stage_t data_reg;
    mfpb_stage_t data_next;
    logic [REM_W-1:0] dsh_ext;
    logic [NCH-1:0]   fits;

    assign dsh_ext = {{(REM_W-DSH_W){1'b0}}, up_data.dsh};

    always_comb
    begin
        data_next     = up_data;
        data_next.dsh = up_data.dsh >> 1;
        for (int i = 0; i < NCH; i++)
        begin
            fits[i]           = (up_data.rem[i] >= dsh_ext);
            data_next.rem[i]  = fits[i] ? (up_data.rem[i] - dsh_ext) : up_data.rem[i];
            data_next.quot[i] = {up_data.quot[i][QUOT_W-2:0], fits[i]};
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ----- rtl/multi_format_pixel_blend.sv -----
// Top level of the multi-format pixel blend unit: front stage, a chain of
// divider cells and the output register. Depends on mfpb_pkg, mfpb_front, mfpb_div_cell.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_stall  | command, pixel_format, src_red/green/blue/alpha,
//          |                      | dst_byte0..dst_byte3
//  out     | out_valid / out_stall| out_byte0..out_byte3
//
//  One request enters per clock while in_stall is low; out_valid rises once it has passed
//  through ten registers: front stage, eight divider cells (one quotient bit each),
//  output register. Every request travels the full chain.
//  Reset (rst_n low, asynchronous) empties every stage; no payload is cleared.
//  Each stage advances when it is empty or its successor advances, so bubbles
//  close up; in_stall rises only when every stage is full and out_stall holds.
module multi_format_pixel_blend (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  logic [1:0] pixel_format,
    input  logic [7:0] src_red,
    input  logic [7:0] src_green,
    input  logic [7:0] src_blue,
    input  logic [7:0] src_alpha,
    input  logic [7:0] dst_byte0,
    input  logic [7:0] dst_byte1,
    input  logic [7:0] dst_byte2,
    input  logic [7:0] dst_byte3,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte0,
    output logic [7:0] out_byte1,
    output logic [7:0] out_byte2,
    output logic [7:0] out_byte3
);
    import mfpb_pkg::*;

    // stage k feeds divider cell k; stage QUOT_W feeds the output register
    mfpb_stage_t stg_data  [0:QUOT_W];
    logic        stg_valid [0:QUOT_W];
    logic        stg_ready [0:QUOT_W];

    logic            front_ready;
    logic            out_valid_reg;
    logic [3:0][7:0] out_bytes_reg;
    logic [3:0][7:0] out_bytes_next;

    mfpb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (in_valid),
        .up_ready     (front_ready),
        .command      (command),
        .pixel_format (pixel_format),
        .src          ({src_alpha, src_blue, src_green, src_red}),
        .dst          ({dst_byte3, dst_byte2, dst_byte1, dst_byte0}),
        .dn_valid     (stg_valid[0]),
        .dn_ready     (stg_ready[0]),
        .dn_data      (stg_data[0])
    );

    assign in_stall = !front_ready;

    // divider chain: each cell resolves one quotient bit, MSB first
    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_cell
        mfpb_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stg_valid[k]),
            .up_ready (stg_ready[k]),
            .up_data  (stg_data[k]),
            .dn_valid (stg_valid[k+1]),
            .dn_ready (stg_ready[k+1]),
            .dn_data  (stg_data[k+1])
        );
    end

    // output register: advance when empty or when the consumer takes the result
    assign stg_ready[QUOT_W] = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_bytes_next = stg_data[QUOT_W].bytes;
        if (stg_data[QUOT_W].use_div)
        begin
            // general RGBA blend: colour from the quotients, alpha already saturated
            for (int i = 0; i < NCH; i++)
            begin
                out_bytes_next[i] = stg_data[QUOT_W].quot[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stg_ready[QUOT_W])
        begin
            out_valid_reg <= stg_valid[QUOT_W];
        end
    end

    // hold the payload while stalled, load a new result on advance
    always_ff @(posedge clk)
    begin
        if (stg_ready[QUOT_W] && stg_valid[QUOT_W])
        begin
            out_bytes_reg <= out_bytes_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte0 = out_bytes_reg[0];
    assign out_byte1 = out_bytes_reg[1];
    assign out_byte2 = out_bytes_reg[2];
    assign out_byte3 = out_bytes_reg[3];

endmodule

// ----- rtl/mfpb_checker.sv -----
// Port-level checks of the multi-format pixel blend unit, bound to the top level.
// Depends on multi_format_pixel_blend only through its ports.
module mfpb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte0,
    input logic [7:0] out_byte1,
    input logic [7:0] out_byte2,
    input logic [7:0] out_byte3
);

    // reset empties the pipeline: no valid output and no input stall
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> (!out_valid && !in_stall))
        else $error("pipeline not empty after reset");

    // input backpressure only comes from a full chain behind a stalled output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(out_byte0) && $stable(out_byte1)
                                     && $stable(out_byte2) && $stable(out_byte3)))
        else $error("stalled result changed");

endmodule

bind multi_format_pixel_blend mfpb_checker u_mfpb_checker (.*);
